### rtl/core/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared constants, command and status types, and index helpers for the
// 4x4 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
`default_nettype none

package mi4_pkg;

  localparam int MAT_DIM   = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int N_ELEM    = MAT_DIM * MAT_DIM;
  localparam int IDX_W     = 4;
  localparam int DIM_W     = 2;
  localparam int OUT_DET_W = 64;

  // 3x3 cofactor: three products of 32-bit elements, six terms
  localparam int COF_W     = 3 * ELEM_W + 1;
  // determinant accumulator, with headroom for four terms and sign
  localparam int DET_W     = COF_W + ELEM_W + 2;
  localparam int PROD_W    = 2 * ELEM_W + 2;
  localparam int NUM_W     = COF_W + 2 * FRAC_BITS;
  localparam int DET_SHIFT = FRAC_BITS * (MAT_DIM - 1);
  localparam int DCNT_W    = 8;

  // multiplier operand select
  localparam logic [2:0] MS_ELEM = 3'd0;
  localparam logic [2:0] MS_LO   = 3'd1;
  localparam logic [2:0] MS_HI   = 3'd2;
  localparam logic [2:0] MS_C0   = 3'd3;
  localparam logic [2:0] MS_C1   = 3'd4;
  localparam logic [2:0] MS_C2   = 3'd5;

  // accumulator shift select
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  typedef struct packed {
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic             e_load;
    logic             hi_load;
    logic [2:0]       mul_sel;
    logic             acc_clear;
    logic             acc_add;
    logic             acc_neg;
    logic [1:0]       acc_shift;
    logic             cof_we;
    logic [IDX_W-1:0] cof_idx;
    logic             det_latch;
    logic             detv_latch;
    logic             div_init;
    logic             div_step;
    logic             emit;
    logic             sing_emit;
    logic [IDX_W-1:0] out_index;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } stat_t;

  // k-th index of the three that differ from i
  function automatic logic [DIM_W-1:0] other_idx(input logic [DIM_W-1:0] i,
                                                 input logic [DIM_W-1:0] k);
    return (k >= i) ? k + 2'd1 : k;
  endfunction

  // column position of row k in 3x3 permutation term t
  function automatic logic [DIM_W-1:0] perm_col(input logic [2:0] t,
                                                input logic [DIM_W-1:0] k);
    logic [5:0] p;
    case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd1, 2'd2, 2'd0};
      3'd2:    p = {2'd2, 2'd0, 2'd1};
      3'd3:    p = {2'd0, 2'd2, 2'd1};
      3'd4:    p = {2'd1, 2'd0, 2'd2};
      3'd5:    p = {2'd0, 2'd1, 2'd2};
      default: p = '0;
    endcase
    return p[k*2+:2];
  endfunction

  function automatic logic perm_neg(input logic [2:0] t);
    return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
  endfunction

endpackage

`default_nettype wire

### rtl/core/mi4_datapath.sv
// ----------------------------------------------------------------------------
// mi4_datapath
// Element store, shared multiplier and wide accumulator, cofactor registers,
// restoring divider and registered result outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mi4_pkg::cmd_t                          cmd,
  input  logic signed [mi4_pkg::ELEM_W-1:0]      element_value,
  output mi4_pkg::stat_t                         stat,
  output logic                                   result_valid,
  output logic signed [mi4_pkg::ELEM_W-1:0]      inverse_value,
  output logic [mi4_pkg::IDX_W-1:0]              element_index,
  output logic signed [mi4_pkg::OUT_DET_W-1:0]   determinant_value,
  output logic                                   singular,
  output logic                                   last
);
  import mi4_pkg::*;

  logic        [ELEM_W-1:0] mem [N_ELEM];
  logic signed [ELEM_W-1:0] rd;
  logic signed [ELEM_W-1:0] e;
  logic signed [ELEM_W-1:0] hi;
  logic signed [ELEM_W:0]   mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [DET_W-1:0]  acc;
  logic signed [DET_W-1:0]  addend;
  logic        [COF_W-1:0]  cof [N_ELEM];
  logic        [COF_W-1:0]  cof_rd;
  logic        [COF_W-1:0]  cof_abs;
  logic        [DET_W-1:0]  dmag;
  logic                     dneg;
  logic        [DET_W-1:0]  dsh;
  logic [OUT_DET_W-1:0]     detv;
  logic [OUT_DET_W-1:0]     detv_next;
  logic        [NUM_W-1:0]  num;
  logic        [DET_W-1:0]  rem;
  logic        [DET_W-1:0]  rem_sh;
  logic                     ge;
  logic        [ELEM_W:0]   q;
  logic                     ovf;
  logic                     qneg;
  logic        [ELEM_W-1:0] qsat;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.mem_waddr] <= element_value;
    end
    rd <= mem[cmd.mem_raddr];
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_ELEM: mul_a = {e[ELEM_W-1], e};
      MS_LO:   mul_a = {1'b0, prod[ELEM_W-1:0]};
      MS_HI:   mul_a = {hi[ELEM_W-1], hi};
      MS_C0:   mul_a = {1'b0, cof_rd[ELEM_W-1:0]};
      MS_C1:   mul_a = {1'b0, cof_rd[2*ELEM_W-1:ELEM_W]};
      MS_C2:   mul_a = cof_rd[COF_W-1:2*ELEM_W];
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.acc_shift)
      SH_0:    addend = DET_W'(prod);
      SH_32:   addend = DET_W'(prod) <<< ELEM_W;
      SH_64:   addend = DET_W'(prod) <<< (2 * ELEM_W);
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * rd;
    if (cmd.e_load) begin
      e <= rd;
    end
    if (cmd.hi_load) begin
      hi <= prod[2*ELEM_W-1:ELEM_W];
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= cmd.acc_neg ? acc - addend : acc + addend;
    end
  end

  assign cof_rd  = cof[cmd.cof_idx];
  assign cof_abs = cof_rd[COF_W-1] ? COF_W'(-cof_rd) : cof_rd;

  always_ff @(posedge clk) begin
    if (cmd.cof_we) begin
      cof[cmd.cof_idx] <= acc[COF_W-1:0];
    end
  end

  // determinant magnitude and saturated output value
  assign dsh = dmag >> DET_SHIFT;

  always_comb begin
    if (dneg) begin
      if ((|dsh[DET_W-1:OUT_DET_W]) ||
          (dsh[OUT_DET_W-1] && (|dsh[OUT_DET_W-2:0]))) begin
        detv_next = {1'b1, {(OUT_DET_W-1){1'b0}}};
      end else begin
        detv_next = -dsh[OUT_DET_W-1:0];
      end
    end else begin
      if (|dsh[DET_W-1:OUT_DET_W-1]) begin
        detv_next = {1'b0, {(OUT_DET_W-1){1'b1}}};
      end else begin
        detv_next = dsh[OUT_DET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.det_latch) begin
      dneg <= acc[DET_W-1];
      dmag <= acc[DET_W-1] ? DET_W'(-acc) : DET_W'(acc);
    end
    if (cmd.detv_latch) begin
      detv <= detv_next;
    end
  end

  assign stat.det_zero = (dmag == '0);

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem[DET_W-2:0], num[NUM_W-1]};
  assign ge     = (rem_sh >= dmag);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num  <= {cof_abs, {(2*FRAC_BITS){1'b0}}};
      rem  <= '0;
      q    <= '0;
      ovf  <= 1'b0;
      qneg <= cof_rd[COF_W-1] ^ dneg;
    end else if (cmd.div_step) begin
      num <= num << 1;
      rem <= ge ? rem_sh - dmag : rem_sh;
      q   <= {q[ELEM_W-1:0], ge};
      ovf <= ovf | q[ELEM_W];
    end
  end

  always_comb begin
    if (qneg) begin
      if (ovf || q[ELEM_W] || (q[ELEM_W-1] && (|q[ELEM_W-2:0]))) begin
        qsat = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        qsat = -q[ELEM_W-1:0];
      end
    end else begin
      if (ovf || q[ELEM_W] || q[ELEM_W-1]) begin
        qsat = {1'b0, {(ELEM_W-1){1'b1}}};
      end else begin
        qsat = q[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit | cmd.sing_emit;
    end
    if (cmd.emit) begin
      inverse_value     <= qsat;
      element_index     <= cmd.out_index;
      determinant_value <= detv;
      singular          <= 1'b0;
      last              <= cmd.out_last;
    end else if (cmd.sing_emit) begin
      inverse_value     <= '0;
      element_index     <= '0;
      determinant_value <= '0;
      singular          <= 1'b1;
      last              <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: element loading, cofactor and determinant multiply-accumulate
// steps, division passes and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module mi4_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mi4_pkg::stat_t stat,
  output mi4_pkg::cmd_t  cmd
);
  import mi4_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_COF  = 4'd1;
  localparam logic [3:0] S_CST  = 4'd2;
  localparam logic [3:0] S_DET  = 4'd3;
  localparam logic [3:0] S_ABS  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DVI  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(N_ELEM - 1);
  localparam logic [2:0]        LAST_TERM = 3'd5;
  localparam logic [DCNT_W-1:0] LAST_DIV = DCNT_W'(NUM_W - 1);

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  ci;
  logic [2:0]        term;
  logic [2:0]        phase;
  logic [DIM_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [DCNT_W-1:0] dcnt;
  logic [DIM_W-1:0]  rsel;
  logic [DIM_W-1:0]  row_k;
  logic [DIM_W-1:0]  col_k;

  assign busy = (state != S_LOAD);

  always_comb begin
    case (phase)
      3'd0:    rsel = 2'd0;
      3'd1:    rsel = 2'd1;
      default: rsel = 2'd2;
    endcase
  end

  assign row_k = other_idx(ci[3:2], rsel);
  assign col_k = other_idx(ci[1:0], perm_col(term, rsel));

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: if (start && cnt == LAST_IDX) state_next = S_COF;
      S_COF:  if (term == LAST_TERM && phase == 3'd5) state_next = S_CST;
      S_CST:  state_next = (ci == LAST_IDX) ? S_DET : S_COF;
      S_DET:  if (j == 2'd3 && phase == 3'd4) state_next = S_ABS;
      S_ABS:  state_next = S_CHK;
      S_CHK:  state_next = stat.det_zero ? S_LOAD : S_DVI;
      S_DVI:  state_next = S_DIV;
      S_DIV:  if (dcnt == LAST_DIV) state_next = S_EMIT;
      S_EMIT: state_next = (k == LAST_IDX) ? S_LOAD : S_DVI;
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      ci    <= '0;
      term  <= '0;
      phase <= '0;
      j     <= '0;
      k     <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_LOAD: begin
          if (start) cnt <= cnt + 1'b1;
          ci    <= '0;
          term  <= '0;
          phase <= '0;
        end
        S_COF: begin
          if (phase == 3'd5) begin
            phase <= '0;
            term  <= (term == LAST_TERM) ? 3'd0 : term + 3'd1;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_CST: begin
          ci    <= ci + 1'b1;
          j     <= '0;
          phase <= '0;
        end
        S_DET: begin
          if (phase == 3'd4) begin
            phase <= '0;
            j     <= j + 1'b1;
          end else begin
            phase <= phase + 3'd1;
          end
        end
        S_CHK: k <= '0;
        S_DVI: dcnt <= '0;
        S_DIV: dcnt <= dcnt + 1'b1;
        S_EMIT: k <= k + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.mem_waddr = cnt;
    cmd.mem_we    = start && (state == S_LOAD);
    cmd.mul_sel   = MS_ELEM;
    cmd.acc_shift = SH_0;
    case (state)
      S_LOAD: cmd.acc_clear = 1'b1;
      S_COF: begin
        cmd.mem_raddr = IDX_W'(row_k * MAT_DIM + col_k);
        cmd.acc_neg   = perm_neg(term) ^ ci[2] ^ ci[0];
        case (phase)
          3'd1: cmd.e_load = 1'b1;
          3'd2: cmd.mul_sel = MS_ELEM;
          3'd3: begin
            cmd.mul_sel = MS_LO;
            cmd.hi_load = 1'b1;
          end
          3'd4: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = MS_HI;
          end
          3'd5: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = SH_32;
          end
          default: begin
          end
        endcase
      end
      S_CST: begin
        cmd.cof_we    = 1'b1;
        cmd.cof_idx   = ci;
        cmd.acc_clear = 1'b1;
      end
      S_DET: begin
        cmd.mem_raddr = IDX_W'(j);
        cmd.cof_idx   = IDX_W'(j);
        case (phase)
          3'd1: cmd.mul_sel = MS_C0;
          3'd2: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = MS_C1;
          end
          3'd3: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = SH_32;
            cmd.mul_sel   = MS_C2;
          end
          3'd4: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = SH_64;
          end
          default: begin
          end
        endcase
      end
      S_ABS: cmd.det_latch = 1'b1;
      S_CHK: begin
        cmd.sing_emit  = stat.det_zero;
        cmd.detv_latch = !stat.det_zero;
      end
      S_DVI: begin
        cmd.cof_idx  = IDX_W'(k[1:0] * MAT_DIM + k[3:2]);
        cmd.div_init = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.out_index = k;
        cmd.out_last  = (k == LAST_IDX);
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_we |-> !busy) else $error("store written while busy");
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cnt) == LAST_IDX) else $error("busy without full matrix");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.out_last) |=> !busy) else $error("busy after last result");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.div_step, cmd.div_init, cmd.emit, cmd.acc_add, cmd.sing_emit}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

### rtl/core/matrix_inverse_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top
// 4x4 signed Q16.16 matrix inverse by cofactors and adjugate.
//
//   channel   handshake               payload
//   input     start && !busy          element_value
//   result    result_valid (1 cycle)  inverse_value, element_index,
//                                     determinant_value, singular, last
//
// loading takes one element per cycle while busy is low; after the sixteenth
// the sequencer computes cofactors and determinant through the one shared
// multiplier, then the magnitude and zero check, then each inverse element
// in the restoring divider.
// a singular matrix gives one result.
// reset is synchronous; busy stays high until the last result is issued.
// results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_4x4_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mi4_pkg::ELEM_W-1:0]    element_value,
  output logic                                 result_valid,
  output logic signed [mi4_pkg::ELEM_W-1:0]    inverse_value,
  output logic [mi4_pkg::IDX_W-1:0]            element_index,
  output logic signed [mi4_pkg::OUT_DET_W-1:0] determinant_value,
  output logic                                 singular,
  output logic                                 last
);
  import mi4_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mi4_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mi4_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .element_value     (element_value),
    .stat              (stat),
    .result_valid      (result_valid),
    .inverse_value     (inverse_value),
    .element_index     (element_index),
    .determinant_value (determinant_value),
    .singular          (singular),
    .last              (last)
  );

endmodule

`default_nettype wire
